FILE: sv/assert_macros.svh
// Assertion helpers; clk and rst_n must exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/pcoef_pkg.sv
package pcoef_pkg;

  localparam int PHASE_W    = 16;
  localparam int COEF_W     = 16;
  localparam int TADDR_W    = 11;
  localparam int HALF_W     = 6;
  localparam int NPH_W      = 7;
  localparam int TAP_W      = 6;
  localparam int CALC_W     = 12;  // computed read addresses reach 2048
  localparam int MAX_HALF_LEN = 32;
  localparam int MAX_PHASES   = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_COUNT = 2'd1;

  localparam logic [HALF_W-1:0] HALF_LEN_RST    = 6'd16;
  localparam logic [NPH_W-1:0]  PHASE_COUNT_RST = 7'd32;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic load;     // write one table word
    logic cap;      // capture row and fraction of a compute item
    logic base1;    // row products
    logic base2;    // row base addresses
    logic issue;    // issue one tap read
    logic upper;    // upper half of the filter
    logic cnt_clr;  // restart tap counter
  } pcoef_cmd_t;

  typedef struct packed {
    logic issue_ok;  // tap pipeline can take a read
    logic cnt_last;  // counter at last tap of this half
  } pcoef_sts_t;

endpackage

FILE: sv/pcoef_in_if.sv
interface pcoef_in_if import pcoef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [TADDR_W-1:0]        table_address;
  logic signed [COEF_W-1:0]  table_value;
  logic [PHASE_W-1:0]        phase;

  modport source (output valid, kind, table_address, table_value, phase, input ready);
  modport sink   (input valid, kind, table_address, table_value, phase, output ready);
endinterface

FILE: sv/pcoef_out_if.sv
interface pcoef_out_if import pcoef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TAP_W-1:0]          tap_index;
  logic signed [COEF_W-1:0]  coefficient;
  logic                      last;

  modport source (output valid, tap_index, coefficient, last, input ready);
  modport sink   (input valid, tap_index, coefficient, last, output ready);
endinterface

FILE: sv/pcoef_cfg_if.sv
interface pcoef_cfg_if import pcoef_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/pcoef_ram.sv
module pcoef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: sv/pcoef_ctrl.sv
module pcoef_ctrl import pcoef_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  input  pcoef_sts_t sts,
  output pcoef_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BASE1 = 3'd1;
  localparam logic [2:0] ST_BASE2 = 3'd2;
  localparam logic [2:0] ST_LOWER = 3'd3;
  localparam logic [2:0] ST_UPPER = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_COMPUTE) begin
            cmd.cap   = 1'b1;
            state_nxt = ST_BASE1;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_BASE1: begin
        cmd.base1 = 1'b1;
        state_nxt = ST_BASE2;
      end
      ST_BASE2: begin
        cmd.base2   = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = ST_LOWER;
      end
      ST_LOWER: begin
        if (sts.issue_ok) begin
          cmd.issue = 1'b1;
          if (sts.cnt_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_UPPER;
          end
        end
      end
      ST_UPPER: begin
        cmd.upper = 1'b1;
        if (sts.issue_ok) begin
          cmd.issue = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/pcoef_dp.sv
`include "assert_macros.svh"

module pcoef_dp import pcoef_pkg::*; #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pcoef_cmd_t               cmd,
  output pcoef_sts_t               sts,
  // input payload
  input  logic [TADDR_W-1:0]       in_table_address,
  input  logic signed [COEF_W-1:0] in_table_value,
  input  logic [PHASE_W-1:0]       in_phase,
  // register writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // results
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TAP_W-1:0]         out_tap_index,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic                     out_last
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int XW   = (AW + 1 > CALC_W) ? AW + 1 : CALC_W;
  localparam int PW   = NPH_W + PHASE_W;
  localparam int MW   = NPH_W + HALF_W;
  localparam int SUMW = 2 * COEF_W + 3;

  // registers
  logic [HALF_W-1:0]  half_len_r;
  logic [NPH_W-1:0]   phase_count_r;
  logic [NPH_W-1:0]   p_r;
  logic [PHASE_W-1:0] f_r;
  logic [CALC_W-1:0]  ub_r, top_r, la_r, lb_r, ua_r;
  logic [HALF_W-1:0]  cnt_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic [TAP_W-1:0]   s1_tap_r;
  logic               s1_last_r;
  logic               s1_ina_r, s1_inb_r;
  logic [PHASE_W-1:0] s1_f_r;
  logic               out_valid_r, out_valid_nxt;
  logic [TAP_W-1:0]   out_tap_r;
  logic [COEF_W-1:0]  out_coef_r;
  logic               out_last_r;

  // clamped settings
  logic [HALF_W-1:0] h_cl;
  logic [NPH_W-1:0]  np_cl;
  logic [HALF_W-1:0] hm1;
  logic [CALC_W-1:0] h_ext;

  assign h_cl = (half_len_r == '0) ? HALF_W'(1) :
                (half_len_r > HALF_W'(MAX_HALF_LEN)) ? HALF_W'(MAX_HALF_LEN) : half_len_r;
  assign np_cl = (phase_count_r == '0) ? NPH_W'(1) :
                 (phase_count_r > NPH_W'(MAX_PHASES)) ? NPH_W'(MAX_PHASES) : phase_count_r;
  assign hm1   = h_cl - HALF_W'(1);
  assign h_ext = CALC_W'(h_cl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_len_r    <= HALF_LEN_RST;
      phase_count_r <= PHASE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_LEN:    half_len_r    <= cfg_data[HALF_W-1:0];
        REG_PHASE_COUNT: phase_count_r <= cfg_data[NPH_W-1:0];
        default: ;
      endcase
    end
  end

  // phase split and row bases
  logic [PW-1:0] prod;
  logic          p_at_top;

  assign prod     = PW'(in_phase) * PW'(np_cl);
  assign p_at_top = (p_r == np_cl - NPH_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      p_r <= prod[PW-1 -: NPH_W];
      f_r <= prod[PHASE_W-1:0];
    end
    if (cmd.base1) begin
      ub_r  <= CALC_W'(MW'(p_r) * MW'(h_cl));
      top_r <= CALC_W'(MW'(np_cl - NPH_W'(1)) * MW'(h_cl));
    end
    if (cmd.base2) begin
      la_r <= top_r - ub_r;
      lb_r <= p_at_top ? top_r + CALC_W'(1) : top_r - ub_r - h_ext;
      ua_r <= (p_r == '0) ? top_r + CALC_W'(1) : ub_r - h_ext;
    end
  end

  // tap counter
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + HALF_W'(1);
    end
  end

  // read issue
  logic [HALF_W-1:0] off;
  logic [CALC_W-1:0] addr_a, addr_b;
  logic [XW-1:0]     addr_a_x, addr_b_x, waddr_x;
  logic              ina, inb, win;

  assign off      = cmd.upper ? cnt_r : hm1 - cnt_r;
  assign addr_a   = (cmd.upper ? ua_r : la_r) + CALC_W'(off);
  assign addr_b   = (cmd.upper ? ub_r : lb_r) + CALC_W'(off);
  assign addr_a_x = XW'(addr_a);
  assign addr_b_x = XW'(addr_b);
  assign waddr_x  = XW'(in_table_address);
  assign ina      = addr_a_x < XW'(TABLE_DEPTH);
  assign inb      = addr_b_x < XW'(TABLE_DEPTH);
  assign win      = waddr_x < XW'(TABLE_DEPTH);

  logic [COEF_W-1:0] rdata_a, rdata_b;

  pcoef_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (cmd.load && win),
    .waddr   (waddr_x[AW-1:0]),
    .wdata   (in_table_value),
    .re      (cmd.issue),
    .raddr_a (addr_a_x[AW-1:0]),
    .raddr_b (addr_b_x[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // stage 1: read data held while output is blocked
  logic s1_adv;
  logic issue_ok;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign issue_ok = !s1_valid_r || s1_adv;

  assign sts.issue_ok = issue_ok;
  assign sts.cnt_last = (cnt_r == hm1);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (cmd.issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // fraction rides with the tap; the next set may capture a new one meanwhile
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_tap_r  <= cmd.upper ? h_cl + cnt_r : cnt_r;
      s1_last_r <= cmd.upper && sts.cnt_last;
      s1_ina_r  <= ina;
      s1_inb_r  <= inb;
      s1_f_r    <= f_r;
    end
  end

  // blend: a*2^16 + (b-a)*f + half, floor shift
  logic [COEF_W-1:0]        a_w, b_w;
  logic signed [COEF_W:0]   diff;
  logic signed [PHASE_W:0]  f_s;
  logic signed [COEF_W+PHASE_W+1:0] mult;
  logic [SUMW-1:0]          sum;

  assign a_w  = s1_ina_r ? rdata_a : '0;
  assign b_w  = s1_inb_r ? rdata_b : '0;
  assign diff = $signed({b_w[COEF_W-1], b_w}) - $signed({a_w[COEF_W-1], a_w});
  assign f_s  = $signed({1'b0, s1_f_r});
  assign mult = diff * f_s;
  assign sum  = {{3{a_w[COEF_W-1]}}, a_w, {PHASE_W{1'b0}}}
              + {mult[COEF_W+PHASE_W+1], mult}
              + SUMW'(1 << (PHASE_W - 1));

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tap_r  <= s1_tap_r;
      out_coef_r <= sum[PHASE_W +: COEF_W];
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tap_index   = out_tap_r;
  assign out_coefficient = out_coef_r;
  assign out_last        = out_last_r;

  `ASSERT_IMPL(a_issue_has_room, cmd.issue, issue_ok)
  `ASSERT_NEXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_tap_r))
  `ASSERT_IMPL(a_last_is_top_tap, out_valid_r && out_last_r,
               {1'b0, out_tap_r} == {h_cl, 1'b0} - 7'd1)

endmodule

FILE: sv/polyphase_coef_interpolator.sv
// Polyphase coefficient interpolator.
// in_ch carries two item kinds. A load item (kind 0) writes table_value to
// table_address and gives no result; addresses at or beyond TABLE_DEPTH are
// dropped. A compute item (kind 1) takes a phase and returns
// 2*half_len coefficients on out_ch, tap_index 0 first, last set on the final
// one. cfg_ch writes half_len (index 0) and phase_count (index 1); it is always
// ready and is meant to be written while no compute set is in flight.
// Timing: after a compute transfer the block forms row bases in states BASE1
// and BASE2, then issues one tap read per cycle from the dual-read table RAM
// unless out_ch stalls. The first coefficient passes the phase, row-base,
// RAM read and output registers in turn; in_ch ready stays low until the
// last tap read of the set has been issued.
// The rate is set by the single tap read/blend path, one tap per cycle when unstalled.
// A stalled out_ch holds the tap in the output register and one more in the
// read stage; reads pause until the receiver takes them, nothing is dropped.
// Reset (rst_n low, synchronous) returns half_len to 16 and phase_count to
// 32 and empties the pipeline; the table holds no defined contents until
// written.
module polyphase_coef_interpolator import pcoef_pkg::*; #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic         clk,
  input  logic         rst_n,
  pcoef_in_if.sink     in_ch,
  pcoef_out_if.source  out_ch,
  pcoef_cfg_if.sink    cfg_ch
);

  pcoef_cmd_t cmd;
  pcoef_sts_t sts;

  // config port never stalls
  assign cfg_ch.ready = 1'b1;

  // sequencer: idle, row bases, lower half, upper half
  pcoef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, address generation, blend and output register
  pcoef_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_table_address (in_ch.table_address),
    .in_table_value   (in_ch.table_value),
    .in_phase         (in_ch.phase),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_tap_index    (out_ch.tap_index),
    .out_coefficient  (out_ch.coefficient),
    .out_last         (out_ch.last)
  );

endmodule

FILE: tb/sv/tb_polyphase_coef_interpolator.sv
`timescale 1ns / 1ps

module tb_polyphase_coef_interpolator;
  import pcoef_pkg::*;

  localparam int TABLE_DEPTH  = 2048;
  // Drain allowance: a full set at the largest half_len plus pipeline slack.
  localparam int DRAIN_CYCLES = 2 * MAX_HALF_LEN + 12;
  // Long receiver hold-off used to back the block up into in_ch.
  localparam int HOLD_CYCLES  = 400;
  // Hang guard.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int N_SETTINGS   = 14;
  // Largest half_len*phase_count footprint used outside the full-table phase.
  localparam int FOOT_WORDS   = 256;
  // Words loaded up front: the footprint plus rows 14..16 at the reset values.
  localparam int PRELOAD_WORDS = 272;

  // One request as the sender sees it.
  typedef struct {
    logic                     kind;
    logic [TADDR_W-1:0]       addr;
    logic signed [COEF_W-1:0] value;
    logic [PHASE_W-1:0]       phase;
  } req_t;

  // One expected coefficient transfer.
  typedef struct {
    logic [TAP_W-1:0]         tap;
    logic signed [COEF_W-1:0] coef;
    logic                     last;
  } tap_t;

  logic clk;
  logic rst_n;

  pcoef_in_if  in_ch  ();
  pcoef_out_if out_ch ();
  pcoef_cfg_if cfg_ch ();

  polyphase_coef_interpolator #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Requests waiting for the sender, and coefficients waiting to come back.
  req_t in_items[$];
  tap_t pending_taps[$];

  // Mirror of the block's table and registers, updated on accepted transfers.
  logic signed [COEF_W-1:0] coef_mirror [TABLE_DEPTH];
  logic [HALF_W-1:0]        half_len_q;
  logic [NPH_W-1:0]         phase_cnt_q;

  int unsigned n_pushed;
  int unsigned n_taken;
  int unsigned errors;
  int unsigned cycles;

  // Transfer flags, set at the rising edge, consumed at the falling edge.
  logic in_taken;
  logic cfg_taken;

  // Idle control, set per phase by the stimulus process (percent; source per transfer, sink per cycle).
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned src_gap;
  int unsigned snk_gap;

  // Long hold-off request: the sink process compares against its own copy.
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Out-of-range words read as zero (the trailing word at P*H on a full table).
  function automatic longint tbl_word(int unsigned addr);
    if (addr >= TABLE_DEPTH) return 0;
    return longint'(coef_mirror[addr]);
  endfunction

  // Linear blend of two Q1.15 words with round-half-up, floor shift.
  function automatic logic signed [COEF_W-1:0] blend(longint a, longint b, longint f);
    longint acc;
    acc = a * ((longint'(1) << PHASE_W) - f) + b * f + (longint'(1) << (PHASE_W - 1));
    return COEF_W'(acc >>> PHASE_W);
  endfunction

  // Expected coefficient set for one compute request under the current registers.
  function automatic void predict_coef_set(logic [PHASE_W-1:0] ph);
    int unsigned h;
    int unsigned np;
    int unsigned prod;
    int unsigned p;
    longint      f;
    longint      a;
    longint      b;
    tap_t        t;
    // out-of-range register values saturate
    h  = (half_len_q == 0) ? 1 :
         (half_len_q > MAX_HALF_LEN) ? MAX_HALF_LEN : half_len_q;
    np = (phase_cnt_q == 0) ? 1 :
         (phase_cnt_q > MAX_PHASES) ? MAX_PHASES : phase_cnt_q;
    prod = int'(ph) * np;
    p    = prod >> PHASE_W;
    f    = longint'(prod % (1 << PHASE_W));
    // lower half mirrors the table, walked so tap 0 comes out first
    for (int k = h - 1; k >= 0; k--) begin
      a = tbl_word((np - 1 - p) * h + k);
      b = (p == np - 1) ? tbl_word((np - 1) * h + 1 + k)
                        : tbl_word((np - 2 - p) * h + k);
      t.tap  = TAP_W'(h - 1 - k);
      t.coef = blend(a, b, f);
      t.last = 1'b0;
      pending_taps.push_back(t);
    end
    // upper half; row 0 wraps to the shifted phase-0 row
    for (int k = 0; k < h; k++) begin
      a = (p == 0) ? tbl_word((np - 1) * h + 1 + k) : tbl_word((p - 1) * h + k);
      b = tbl_word(p * h + k);
      t.tap  = TAP_W'(h + k);
      t.coef = blend(a, b, f);
      t.last = (k == h - 1);
      pending_taps.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: samples all three channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tap_t got;
    tap_t want;
    if (!rst_n) begin
      half_len_q  <= HALF_LEN_RST;
      phase_cnt_q <= PHASE_COUNT_RST;
      in_taken    <= 1'b0;
      cfg_taken   <= 1'b0;
    end else begin
      in_taken  <= in_ch.valid && in_ch.ready;
      cfg_taken <= cfg_ch.valid && cfg_ch.ready;

      // register writes update the mirror at once; the stimulus writes only while nothing is in flight
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_HALF_LEN)
          half_len_q <= cfg_ch.data[HALF_W-1:0];
        else if (cfg_ch.index == REG_PHASE_COUNT)
          phase_cnt_q <= cfg_ch.data;
      end

      if (in_ch.valid && in_ch.ready) begin
        n_taken++;
        if (in_ch.kind == KIND_LOAD)
          coef_mirror[in_ch.table_address] = in_ch.table_value;
        else
          predict_coef_set(in_ch.phase);
      end

      if (out_ch.valid && out_ch.ready) begin
        got.tap  = out_ch.tap_index;
        got.coef = out_ch.coefficient;
        got.last = out_ch.last;
        if (pending_taps.size() == 0) begin
          $display("%0t: unexpected coefficient: expected none, got tap %0d coef %0d last %0b",
                   $time, got.tap, got.coef, got.last);
          errors++;
        end else begin
          want = pending_taps.pop_front();
          if (got.tap !== want.tap || got.coef !== want.coef || got.last !== want.last) begin
            $display("%0t: coefficient mismatch: expected tap %0d coef %0d last %0b, got tap %0d coef %0d last %0b",
                     $time, want.tap, want.coef, want.last, got.tap, got.coef, got.last);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents the head of in_items, holds it until the transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_taken) begin
        void'(in_items.pop_front());
        // idle burst only between transfers, never with valid pending
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
          src_gap = $urandom_range(1, 13);
      end
      if (src_gap != 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (in_items.size() != 0) begin
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= in_items[0].kind;
        in_ch.table_address <= in_items[0].addr;
        in_ch.table_value   <= in_items[0].value;
        in_ch.phase         <= in_items[0].phase;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
      snk_gap = $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_load(int unsigned addr, logic signed [COEF_W-1:0] val);
    req_t r;
    r.kind  = KIND_LOAD;
    r.addr  = TADDR_W'(addr);
    r.value = val;
    r.phase = PHASE_W'($urandom);
    in_items.push_back(r);
    n_pushed++;
  endtask

  task automatic push_compute(logic [PHASE_W-1:0] ph);
    req_t r;
    r.kind  = KIND_COMPUTE;
    r.addr  = TADDR_W'($urandom);
    r.value = COEF_W'($urandom);
    r.phase = ph;
    in_items.push_back(r);
    n_pushed++;
  endtask

  // Random word, weighted toward full scale.
  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Phase weighted toward row boundaries: f near zero, f near one, and the ends.
  function automatic logic [PHASE_W-1:0] rand_phase(int unsigned np);
    int unsigned k;
    k = $urandom_range(0, np - 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PHASE_W'((k * 65536 + np - 1) / np);
      3:       return PHASE_W'(((k + 1) * 65536) / np - 1);
      default: return PHASE_W'($urandom);
    endcase
  endfunction

  // Rows 15 and 16 at the reset registers; they read only preloaded words.
  function automatic logic [PHASE_W-1:0] mid_phase();
    return PHASE_W'(32'h7800 + $urandom_range(0, 32'h0FFF));
  endfunction

  // First or last row at 64 phases, where both halves wrap.
  function automatic logic [PHASE_W-1:0] edge_phase();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return PHASE_W'($urandom_range(0, 1023));
      default: return PHASE_W'($urandom_range(32'hFC00, 32'hFFFF));
    endcase
  endfunction

  // Everything accepted and every coefficient returned.
  task automatic wait_drained();
    do @(negedge clk); while (n_taken != n_pushed || pending_taps.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  // Register settings per phase; includes the extremes and the saturating
  // values (zero, and above the legal maximum, incl. a half_len write whose
  // dropped top bit leaves zero). Footprints stay within FOOT_WORDS except
  // the full-table phase (index 1).
  logic [CFG_DATA_W-1:0] half_set  [N_SETTINGS] =
    '{7'd1, 7'd32, 7'd0, 7'd63, 7'd33, 7'd4, 7'd1, 7'd8, 7'h7F, 7'h40, 7'd5,
      7'd0, 7'd0, 7'd16};
  logic [CFG_DATA_W-1:0] phase_set [N_SETTINGS] =
    '{7'd1, 7'd64, 7'd0, 7'd5, 7'd1, 7'd127, 7'd64, 7'd5, 7'd3, 7'd100, 7'd13,
      7'd0, 7'd0, 7'd16};

  initial begin
    int unsigned hv;
    int unsigned pv;
    int unsigned np_eff;
    int unsigned n_items;

    // known levels on every block input from time zero
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_LOAD;
    in_ch.table_address = '0;
    in_ch.table_value   = '0;
    in_ch.phase         = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_HALF_LEN;
    cfg_ch.data         = '0;
    src_idle_pct        = 10;
    snk_idle_pct        = 10;
    hold_req            = 0;
    hold_seen           = 0;
    hold_left           = 0;
    n_pushed            = 0;
    n_taken             = 0;
    errors              = 0;
    cycles              = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Table is undefined after reset: load every word a compute will read.
    for (int a = 0; a < PRELOAD_WORDS; a++)
      push_load(a, rand_coef());

    // Directed, reset register values (half_len 16, 32 phases), rows 15/16.
    push_load(0, 16'sh7FFF);
    push_load(TABLE_DEPTH - 1, 16'sh8000);
    push_load(240, 16'sh8000);
    push_load(271, 16'sh7FFF);     // top word of row 16
    push_compute(16'h8000);        // row 16, f = 0
    push_compute(16'h7800);        // exactly row 15
    push_compute(16'h87FF);        // row 16, fraction just under one
    push_compute(16'h7801);        // row 15, tiny fraction
    push_compute(16'h7FFF);        // row 15, largest fraction
    push_compute(16'h8555);
    push_compute(16'h7AAA);
    push_load(240, 16'sh7FFF);     // overwrite, then read it back
    push_compute(16'h7800);
    wait_drained();

    // Back-pressure: receiver holds off while the sender keeps offering.
    hold_req++;
    for (int n = 0; n < 20; n++)
      push_compute(mid_phase());
    // sender then waits for every coefficient before going on
    wait_drained();

    for (int s = 0; s < N_SETTINGS; s++) begin
      wait_drained();
      // loads leave nothing to wait on; give the pipeline time to settle
      repeat (DRAIN_CYCLES) @(negedge clk);

      hv = half_set[s];
      pv = phase_set[s];
      // two random settings near the end
      if (s == N_SETTINGS - 3 || s == N_SETTINGS - 2) begin
        hv = $urandom_range(1, MAX_HALF_LEN);
        pv = $urandom_range(1, (FOOT_WORDS / hv < MAX_PHASES) ? FOOT_WORDS / hv
                                                              : MAX_PHASES);
      end
      write_reg(REG_HALF_LEN, CFG_DATA_W'(hv));
      write_reg(REG_PHASE_COUNT, CFG_DATA_W'(pv));
      np_eff = (pv == 0) ? 1 : (pv > MAX_PHASES) ? MAX_PHASES : pv;

      // full table: load the top two rows; phases stay in the wrapping rows
      if (s == 1)
        for (int a = TABLE_DEPTH - 2 * MAX_HALF_LEN; a < TABLE_DEPTH; a++)
          push_load(a, rand_coef());

      // per-phase idling: sometimes none, last phase always none
      if (s == N_SETTINGS - 1 || $urandom_range(0, 3) == 0) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else begin
        src_idle_pct = $urandom_range(5, 40);
        snk_idle_pct = $urandom_range(3, 25);
      end

      n_items = 14;
      for (int n = 0; n < n_items; n++) begin
        // one mid-phase pause until the block is empty
        if (s == 4 && n == n_items / 2)
          wait_drained();
        if ($urandom_range(0, 9) < 3)
          push_load($urandom_range(0, TABLE_DEPTH - 1), rand_coef());
        else if (s == 1)
          push_compute(edge_phase());
        else
          push_compute(rand_phase(np_eff));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
